### rtl/avgduty_pkg.sv
// Package for the averaging filter and duty mapper: widths, register indexes,
// control word layout and the microprogram table. No dependencies.
package avgduty_pkg;

    // Filter geometry
    localparam int AVG_SHIFT = 4;
    localparam int ADC_W     = 12;
    localparam int SUM_W     = ADC_W + AVG_SHIFT;
    localparam int CNT_W     = AVG_SHIFT;
    localparam int FS_W      = 13;
    localparam int DUTY_W    = 16;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 3;
    localparam int DCNT_W    = $clog2(ADC_W + 1);

    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(ADC_W);

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_FLOOR_TGT = 3'd0;
    localparam logic [IDX_W-1:0] REG_FLOOR_FB  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FULL      = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIV_TGT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIV_FB    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DUTY_LO   = 3'd5;
    localparam logic [IDX_W-1:0] REG_DUTY_HI   = 3'd6;

    // Micro-operations
    typedef enum logic [2:0] {
        OP_LOAD,    // take a sample transfer
        OP_FILT,    // update the channel filter
        OP_PREP,    // clamp the average, set up the divider
        OP_DIV,     // one restoring division step
        OP_DUTY     // offset, clamp, load the output register
    } op_t;

    // Jump conditions; a true condition jumps to the target step
    typedef enum logic [1:0] {
        JC_NONE,
        JC_NO_INPUT,
        JC_DIV_MORE,
        JC_OUT_BUSY
    } jc_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_LOAD = 3'd0;
    localparam step_t STEP_DIV  = 3'd3;
    localparam step_t STEP_DUTY = 3'd4;
    localparam step_t STEP_LAST = 3'd4;

    typedef struct packed {
        op_t   op;
        jc_t   jc;
        step_t target;
    } ctrl_word_t;

    // Microprogram table
    function automatic ctrl_word_t rom_word(input step_t step);
        ctrl_word_t w;
        case (step)
            3'd0:    w = '{op: OP_LOAD, jc: JC_NO_INPUT, target: STEP_LOAD};
            3'd1:    w = '{op: OP_FILT, jc: JC_NONE,     target: STEP_LOAD};
            3'd2:    w = '{op: OP_PREP, jc: JC_NONE,     target: STEP_LOAD};
            3'd3:    w = '{op: OP_DIV,  jc: JC_DIV_MORE, target: STEP_DIV};
            3'd4:    w = '{op: OP_DUTY, jc: JC_OUT_BUSY, target: STEP_DUTY};
            default: w = '{op: OP_LOAD, jc: JC_NONE,     target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

### rtl/adc_average_to_duty.sv
// Top level: two-channel moving-average filter with duty mapping, run by a
// microprogrammed sequencer. Depends on avgduty_pkg.

// One sample is handled at a time. From its transfer to its result being
// loaded, the sequencer takes the sample, updates the filter, clamps the
// average, runs twelve iterations of the bit-serial divider that turns
// the offset above the floor into duty steps, and forms and clamps the
// duty value. The next sample is taken in the cycle after
// that, while the result waits in the output register; if the previous result
// is still untaken the sequencer holds at its last step. Configuration writes
// take effect at once and belong only to idle periods.
module adc_average_to_duty (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [avgduty_pkg::IDX_W-1:0]     cfg_index,
    input  logic [avgduty_pkg::CFG_W-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              channel,
    input  logic [avgduty_pkg::ADC_W-1:0]     sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [avgduty_pkg::DUTY_W-1:0]    duty,
    output logic [avgduty_pkg::ADC_W-1:0]     average,
    output logic                              warming
);
    import avgduty_pkg::*;

    // Configuration registers
    logic [ADC_W-1:0]  floor_tgt_reg, floor_fb_reg;
    logic [FS_W-1:0]   full_reg;
    logic [ADC_W-1:0]  div_tgt_reg, div_fb_reg;
    logic [DUTY_W-1:0] duty_lo_reg, duty_hi_reg;

    // Per-channel filter state
    logic [SUM_W-1:0] sum_reg   [2];
    logic [ADC_W-1:0] avg_reg   [2];
    logic [CNT_W-1:0] cnt_reg   [2];
    logic             steady_reg[2];

    // Sequencer and datapath registers
    step_t             step_reg, step_next;
    logic              ch_reg;
    logic [ADC_W-1:0]  smp_reg;
    logic [ADC_W-1:0]  quot_reg, quot_next;
    logic [ADC_W-1:0]  rem_reg, rem_next;
    logic [ADC_W-1:0]  dvs_reg, dvs_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [ADC_W-1:0]  average_reg, average_next;
    logic              warming_reg, warming_next;

    ctrl_word_t cw;
    logic       jump;
    logic       accept;
    logic       out_busy;
    logic       do_duty;

    // Filter datapath
    logic [SUM_W-1:0] sum_sel, sum_new;
    logic [ADC_W-1:0] avg_sel, avg_new;
    logic [CNT_W-1:0] cnt_sel, cnt_new;
    logic             steady_sel, steady_new;

    // Clamp, divide and duty datapath
    logic [ADC_W-1:0]  flr_sel, dvs_sel;
    logic [FS_W-1:0]   a_lo, a_cl;
    logic [ADC_W:0]    trial;
    logic [DUTY_W:0]   duty_sum;

    assign cw       = rom_word(step_reg);
    assign out_busy = out_valid_reg && !out_ready;
    assign in_ready = (cw.op == OP_LOAD);
    assign accept   = in_ready && in_valid;
    assign do_duty  = (cw.op == OP_DUTY) && !out_busy;

    // Step counter: jump on condition, else fall through and wrap
    always_comb
    begin
        case (cw.jc)
            JC_NONE:     jump = 1'b0;
            JC_NO_INPUT: jump = !in_valid;
            JC_DIV_MORE: jump = (dcnt_reg != DCNT_W'(1));
            JC_OUT_BUSY: jump = out_busy;
            default:     jump = 1'b0;
        endcase
        if (jump)
            step_next = cw.target;
        else if (step_reg == STEP_LAST)
            step_next = STEP_LOAD;
        else
            step_next = step_reg + STEP_W'(1);
    end

    // Filter update for the selected channel
    always_comb
    begin
        sum_sel    = sum_reg[ch_reg];
        avg_sel    = avg_reg[ch_reg];
        cnt_sel    = cnt_reg[ch_reg];
        steady_sel = steady_reg[ch_reg];
        avg_new    = avg_sel;
        cnt_new    = cnt_sel;
        steady_new = steady_sel;
        if (!steady_sel)
        begin
            sum_new = sum_sel + SUM_W'(smp_reg);
            if (cnt_sel == CNT_MAX)
            begin
                cnt_new    = '0;
                avg_new    = sum_new[SUM_W-1:AVG_SHIFT];
                steady_new = 1'b1;
            end
            else
            begin
                cnt_new = cnt_sel + CNT_W'(1);
            end
        end
        else
        begin
            sum_new = sum_sel - SUM_W'(avg_sel) + SUM_W'(smp_reg);
            avg_new = sum_new[SUM_W-1:AVG_SHIFT];
        end
    end

    // Clamp, division step and duty forming
    always_comb
    begin
        flr_sel = ch_reg ? floor_fb_reg : floor_tgt_reg;
        dvs_sel = ch_reg ? div_fb_reg : div_tgt_reg;
        if (dvs_sel == '0)
            dvs_sel = ADC_W'(1);

        // floor first, full scale last so it wins
        a_lo = (avg_sel <= flr_sel) ? FS_W'(flr_sel) : FS_W'(avg_sel);
        a_cl = (a_lo >= full_reg) ? full_reg : a_lo;

        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dcnt_next = dcnt_reg;
        trial     = {rem_reg, quot_reg[ADC_W-1]};

        case (cw.op)
            OP_PREP:
            begin
                quot_next = (a_cl > FS_W'(flr_sel)) ?
                            ADC_W'(a_cl - FS_W'(flr_sel)) : '0;
                rem_next  = '0;
                dvs_next  = dvs_sel;
                dcnt_next = DIV_STEPS;
            end
            OP_DIV:
            begin
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next  = ADC_W'(trial - {1'b0, dvs_reg});
                    quot_next = {quot_reg[ADC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[ADC_W-1:0];
                    quot_next = {quot_reg[ADC_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DCNT_W'(1);
            end
            default:
            begin
            end
        endcase

        // offset is never negative, so only the upper limit matters
        duty_sum = {1'b0, duty_lo_reg} + (DUTY_W+1)'(quot_reg);
        if (duty_sum >= {1'b0, duty_hi_reg})
            duty_next = duty_hi_reg;
        else
            duty_next = duty_sum[DUTY_W-1:0];

        average_next = avg_sel;
        warming_next = !steady_sel;

        if (do_duty)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_LOAD;
            out_valid_reg <= 1'b0;
            floor_tgt_reg <= '0;
            floor_fb_reg  <= '0;
            full_reg      <= FS_W'(4095);
            div_tgt_reg   <= ADC_W'(1);
            div_fb_reg    <= ADC_W'(1);
            duty_lo_reg   <= '0;
            duty_hi_reg   <= '1;
            for (int i = 0; i < 2; i++)
            begin
                sum_reg[i]    <= '0;
                avg_reg[i]    <= '0;
                cnt_reg[i]    <= '0;
                steady_reg[i] <= 1'b0;
            end
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FLOOR_TGT: floor_tgt_reg <= cfg_data[ADC_W-1:0];
                    REG_FLOOR_FB:  floor_fb_reg  <= cfg_data[ADC_W-1:0];
                    REG_FULL:      full_reg      <= cfg_data[FS_W-1:0];
                    REG_DIV_TGT:   div_tgt_reg   <= cfg_data[ADC_W-1:0];
                    REG_DIV_FB:    div_fb_reg    <= cfg_data[ADC_W-1:0];
                    REG_DUTY_LO:   duty_lo_reg   <= cfg_data[DUTY_W-1:0];
                    REG_DUTY_HI:   duty_hi_reg   <= cfg_data[DUTY_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cw.op == OP_FILT)
            begin
                sum_reg[ch_reg]    <= sum_new;
                avg_reg[ch_reg]    <= avg_new;
                cnt_reg[ch_reg]    <= cnt_new;
                steady_reg[ch_reg] <= steady_new;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= channel;
            // target samples drop their low bit
            smp_reg <= channel ? sample : {sample[ADC_W-1:1], 1'b0};
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        dcnt_reg <= dcnt_next;
        if (do_duty)
        begin
            duty_reg    <= duty_next;
            average_reg <= average_next;
            warming_reg <= warming_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;
    assign average   = average_reg;
    assign warming   = warming_reg;

endmodule
